FILE: src/grt_pkg.sv
// Shared types, constants and font lookup for the glyph text rasterizer.
// Used by grt_seq, grt_clip and glyph_text_rasterizer_core; depends on nothing.
`timescale 1ns / 1ps

package grt_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 240;
  localparam int unsigned SCREEN_HEIGHT_DEF = 320;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

  localparam int unsigned CURSOR_W = 12;
  // Cursor plus up to six glyph pixels of scale 15 needs one more bit.
  localparam int unsigned COORD_W  = CURSOR_W + 1;
  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned RECT_X_W = 8;
  localparam int unsigned RECT_Y_W = 9;
  localparam int unsigned GIDX_W   = 6;

  localparam logic signed [CURSOR_W-1:0] CURSOR_MAX = 12'sd2047;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 2'd2;

  // Character codes recognized by the font.
  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CODE_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CODE_W-1:0] CH_DIGIT_9 = 8'h39;
  localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [CODE_W-1:0] CH_PERIOD  = 8'h2E;
  localparam logic [CODE_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CODE_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CODE_W-1:0] CH_EXCLAIM = 8'h21;
  localparam logic [CODE_W-1:0] CASE_FOLD  = 8'h20;

  // Font rows: letters, then digits, then the punctuation glyphs.
  localparam logic [GIDX_W-1:0] GI_DIGIT_0 = 6'd26;
  localparam logic [GIDX_W-1:0] GI_SPACE   = 6'd36;
  localparam logic [GIDX_W-1:0] GI_DASH    = 6'd37;
  localparam logic [GIDX_W-1:0] GI_PERIOD  = 6'd38;
  localparam logic [GIDX_W-1:0] GI_COLON   = 6'd39;
  localparam logic [GIDX_W-1:0] GI_SLASH   = 6'd40;
  localparam logic [GIDX_W-1:0] GI_QMARK   = 6'd41;
  localparam logic [GIDX_W-1:0] GI_EXCLAIM = 6'd42;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // One glyph pixel square before clipping.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SCALE_W-1:0]        side;
    logic                      lit;
    logic                      last;
  } cell_t;

  // Clipped square; all other fields zero when empty.
  typedef struct packed {
    logic [RECT_X_W-1:0] x;
    logic [RECT_Y_W-1:0] y;
    logic [SCALE_W-1:0]  w;
    logic [SCALE_W-1:0]  h;
    logic                empty;
  } rect_t;

  function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0]  up;
    logic [GIDX_W-1:0]  idx;
    up = code;
    if (code >= CH_LOWER_A && code <= CH_LOWER_Z) up = code - CASE_FOLD;
    if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
      idx = GIDX_W'(up - CH_UPPER_A);
    end else if (up >= CH_DIGIT_0 && up <= CH_DIGIT_9) begin
      idx = GI_DIGIT_0 + GIDX_W'(up - CH_DIGIT_0);
    end else if (up == CH_SPACE) begin
      idx = GI_SPACE;
    end else if (up == CH_DASH) begin
      idx = GI_DASH;
    end else if (up == CH_PERIOD) begin
      idx = GI_PERIOD;
    end else if (up == CH_COLON) begin
      idx = GI_COLON;
    end else if (up == CH_SLASH) begin
      idx = GI_SLASH;
    end else if (up == CH_EXCLAIM) begin
      idx = GI_EXCLAIM;
    end else begin
      idx = GI_QMARK;
    end
    return idx;
  endfunction

  // Packs five column bytes so that bit col*7+row holds the pixel; bit 0 is the top row.
  function automatic logic [GLYPH_BITS-1:0] pack_cols(input logic [7:0] c0, input logic [7:0] c1,
                                                      input logic [7:0] c2, input logic [7:0] c3,
                                                      input logic [7:0] c4);
    return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GIDX_W-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    unique case (idx)
      6'd0:  g = pack_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      6'd1:  g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd2:  g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      6'd3:  g = pack_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      6'd4:  g = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      6'd5:  g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      6'd6:  g = pack_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      6'd7:  g = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      6'd8:  g = pack_cols(8'h41, 8'h41, 8'h7F, 8'h41, 8'h41);
      6'd9:  g = pack_cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      6'd10: g = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      6'd11: g = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      6'd12: g = pack_cols(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
      6'd13: g = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      6'd14: g = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      6'd15: g = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      6'd16: g = pack_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      6'd17: g = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      6'd18: g = pack_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      6'd19: g = pack_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      6'd20: g = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      6'd21: g = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      6'd22: g = pack_cols(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
      6'd23: g = pack_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      6'd24: g = pack_cols(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      6'd25: g = pack_cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      6'd26: g = pack_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      6'd27: g = pack_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      6'd28: g = pack_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      6'd29: g = pack_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      6'd30: g = pack_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      6'd31: g = pack_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      6'd32: g = pack_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      6'd33: g = pack_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      6'd34: g = pack_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd35: g = pack_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      6'd36: g = pack_cols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      6'd37: g = pack_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      6'd38: g = pack_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      6'd39: g = pack_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      6'd40: g = pack_cols(8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
      6'd42: g = pack_cols(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      default: g = pack_cols(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
    endcase
    return g;
  endfunction

endpackage

FILE: src/grt_clip.sv
// Clips one glyph pixel square against the screen edges.
// Depends on grt_pkg for the cell and rectangle types.
`timescale 1ns / 1ps

module grt_clip #(
  parameter int unsigned SCREEN_WIDTH  = grt_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = grt_pkg::SCREEN_HEIGHT_DEF
) (
  input  grt_pkg::cell_t cell_i,
  output grt_pkg::rect_t rect_o
);
  import grt_pkg::*;

  // One bit of headroom over the coordinates so that sums never wrap.
  localparam int unsigned CLIP_W = COORD_W + 1;

  logic signed [CLIP_W-1:0] xe, ye, side, scr_w, scr_h;
  logic signed [CLIP_W-1:0] x1, y1, w1, h1, w2, h2;
  logic                     empty;

  assign xe    = CLIP_W'(cell_i.x);
  assign ye    = CLIP_W'(cell_i.y);
  assign side  = signed'({(CLIP_W - SCALE_W)'(0), cell_i.side});
  assign scr_w = signed'(CLIP_W'(SCREEN_WIDTH));
  assign scr_h = signed'(CLIP_W'(SCREEN_HEIGHT));

  always_comb begin
    if (xe < 0) begin
      x1 = '0;
      w1 = side + xe;
    end else begin
      x1 = xe;
      w1 = side;
    end
    if (ye < 0) begin
      y1 = '0;
      h1 = side + ye;
    end else begin
      y1 = ye;
      h1 = side;
    end
    w2 = (x1 + w1 > scr_w) ? scr_w - x1 : w1;
    h2 = (y1 + h1 > scr_h) ? scr_h - y1 : h1;
    empty = (w2 <= 0) || (h2 <= 0);
  end

  always_comb begin
    if (empty) begin
      rect_o       = '0;
      rect_o.empty = 1'b1;
    end else begin
      rect_o.x     = x1[RECT_X_W-1:0];
      rect_o.y     = y1[RECT_Y_W-1:0];
      rect_o.w     = w2[SCALE_W-1:0];
      rect_o.h     = h2[SCALE_W-1:0];
      rect_o.empty = 1'b0;
    end
  end

endmodule

FILE: src/grt_seq.sv
// Cell sequencer: holds the text cursor and walks the 35 cells of a glyph
// with one shared coordinate adder. Depends on grt_pkg.
`timescale 1ns / 1ps

module grt_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [grt_pkg::CODE_W-1:0]         char_code_i,
  input  logic                               start_new_i,
  input  logic signed [grt_pkg::CURSOR_W-1:0] start_x_i,
  input  logic signed [grt_pkg::CURSOR_W-1:0] start_y_i,
  input  logic [grt_pkg::SCALE_W-1:0]        scale_i,
  input  logic                               out_free_i,
  output logic                               step_o,
  output grt_pkg::cell_t                     cell_o
);
  import grt_pkg::*;

  localparam int unsigned COL_W = $clog2(GLYPH_COLS);
  localparam int unsigned ROW_W = $clog2(GLYPH_ROWS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  seq_state_e state_q, state_d;

  logic signed [CURSOR_W-1:0] cur_col_q, cur_row_q;
  logic signed [COORD_W-1:0]  x_q, y_q;
  logic [COL_W-1:0]           col_q;
  logic [ROW_W-1:0]           row_q;
  logic [SCALE_W-1:0]         side_q;
  logic [GLYPH_BITS-1:0]      glyph_q;

  logic                       accept, last;
  logic signed [CURSOR_W-1:0] base_col, base_row;
  logic signed [COORD_W-1:0]  add_a, add_sum;
  logic [SCALE_W:0]           add_b;

  assign accept   = in_ready_o && in_valid_i;
  assign last     = (col_q == LAST_COL) && (row_q == LAST_ROW);
  assign base_col = start_new_i ? start_x_i : cur_col_q;
  assign base_row = start_new_i ? start_y_i : cur_row_q;

  // Shared adder: next row, next column, or the cursor advance of six pixels,
  // taken as the x of the last column plus two more pixels.
  always_comb begin
    if (last) begin
      add_a = x_q;
      add_b = {side_q, 1'b0};
    end else if (row_q == LAST_ROW) begin
      add_a = x_q;
      add_b = {1'b0, side_q};
    end else begin
      add_a = y_q;
      add_b = {1'b0, side_q};
    end
    add_sum = add_a + signed'({(COORD_W - SCALE_W - 1)'(0), add_b});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (step_o && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    step_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  step_o     = out_free_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cur_col_q <= base_col;
        cur_row_q <= base_row;
        col_q     <= '0;
        row_q     <= '0;
      end else if (step_o) begin
        if (last) begin
          cur_col_q <= (add_sum > COORD_W'(CURSOR_MAX)) ? CURSOR_MAX
                                                      : add_sum[CURSOR_W-1:0];
        end else if (row_q == LAST_ROW) begin
          col_q <= col_q + 1'b1;
          row_q <= '0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= COORD_W'(base_col);
      y_q     <= COORD_W'(base_row);
      side_q  <= (scale_i == '0) ? SCALE_W'(1) : scale_i;
      glyph_q <= font_glyph(glyph_index(char_code_i));
    end else if (step_o) begin
      glyph_q <= glyph_q >> 1;
      if (!last && row_q == LAST_ROW) begin
        x_q <= add_sum;
        y_q <= COORD_W'(cur_row_q);
      end else if (!last) begin
        y_q <= add_sum;
      end
    end
  end

  assign cell_o.x    = x_q;
  assign cell_o.y    = y_q;
  assign cell_o.side = side_q;
  assign cell_o.lit  = glyph_q[0];
  assign cell_o.last = last;

endmodule

FILE: src/glyph_text_rasterizer_core.sv
// Top level of the glyph text rasterizer: configuration registers, the cell
// sequencer, the clipper and the result register. Depends on grt_pkg, grt_seq, grt_clip.
`timescale 1ns / 1ps

// Draws one 5x7 character per input transfer as 35 filled squares, one result
// transfer per cell in column then row order, the last one marked by tlast.
// A character is taken and its font looked up while the block is idle, then
// its cells follow one after another, because a single sequencer steps every
// cell through one shared coordinate adder and the clipper. The input is not
// ready while a character is being drawn; a stalled output holds the
// sequencer. Configuration writes are taken every cycle and should be made
// only while the block is idle.
module glyph_text_rasterizer_core #(
  parameter int unsigned SCREEN_WIDTH  = grt_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = grt_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [31:0]                     s_axis_tdata_i,  // char_code, start_x, start_y
  input  logic                            s_axis_tuser_i,  // start_new
  // Result items.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [47:0]                     m_axis_tdata_o,  // rect_x, rect_y, rect_w,
                                                           // rect_h, fill_color, zero pad
  output logic                            m_axis_tuser_o,  // is_empty
  output logic                            m_axis_tlast_o,  // last_cell
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [grt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [grt_pkg::COLOR_W-1:0]     cfg_data_i
);
  import grt_pkg::*;

  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [SCALE_W-1:0] scale_q;

  logic               step, out_free;
  cell_t              seq_cell;
  rect_t              rect;

  logic               out_valid_q, out_valid_d;
  rect_t              out_rect_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= '1;
      bg_q    <= '0;
      scale_q <= SCALE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FG_COLOR:    fg_q    <= cfg_data_i;
        CFG_BG_COLOR:    bg_q    <= cfg_data_i;
        CFG_GLYPH_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  grt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_code_i (s_axis_tdata_i[7:0]),
    .start_new_i (s_axis_tuser_i),
    .start_x_i   (signed'(s_axis_tdata_i[19:8])),
    .start_y_i   (signed'(s_axis_tdata_i[31:20])),
    .scale_i     (scale_q),
    .out_free_i  (out_free),
    .step_o      (step),
    .cell_o      (seq_cell)
  );

  grt_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_clip (
    .cell_i (seq_cell),
    .rect_o (rect)
  );

  // The result register frees up in the same cycle its transfer completes.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rect_q  <= rect;
      out_color_q <= rect.empty ? '0 : (seq_cell.lit ? fg_q : bg_q);
      out_last_q  <= seq_cell.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_color_q, out_rect_q.h, out_rect_q.w,
                            out_rect_q.y, out_rect_q.x};
  assign m_axis_tuser_o  = out_rect_q.empty;
  assign m_axis_tlast_o  = out_last_q;

  // An empty square carries an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("empty square with nonzero payload");

  // A drawn square always has a size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (out_rect_q.w != '0 && out_rect_q.h != '0))
    else $error("drawn square with zero width or height");

  // Once a character is taken the block is busy drawing it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after a character transfer");

endmodule
